// File: sv/prd_pkg.sv
// prd_pkg: widths, register indexes, payload structs and the depth saturation
// function shared by the projective depth range block
// no dependencies
`default_nettype none

package prd_pkg;

    localparam int COORD_W  = 32;
    localparam int MARGIN_W = 17;
    localparam int FRAC_W   = 16;
    localparam int DEPTH_W  = 48;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int SAT_W    = DEPTH_W + 3;
    localparam int MPROD_W  = DEPTH_W + MARGIN_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    localparam int unsigned MIN_START_DEPTH = 99999;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic signed [DEPTH_W-1:0] MIN_START =
        DEPTH_W'(MIN_START_DEPTH) << FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X      = 3'd0,
        REG_ROW_Y      = 3'd1,
        REG_ROW_Z      = 3'd2,
        REG_ROW_OFFSET = 3'd3,
        REG_MARGIN     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] offset;
    } coef_t;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic                      last;
    } depth_beat_t;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] lo;
        logic signed [DEPTH_W-1:0] hi;
    } range_t;

    function automatic logic signed [DEPTH_W-1:0] sat_depth(
        input logic signed [SAT_W-1:0] v
    );
        logic [3:0] top;
        top = v[SAT_W-1:DEPTH_W-1];
        if (top == 4'b0000 || top == 4'b1111) begin
            return v[DEPTH_W-1:0];
        end else if (v[SAT_W-1]) begin
            return DEPTH_MIN;
        end else begin
            return DEPTH_MAX;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/prd_depth.sv
// prd_depth: three stage pipeline from point to saturated projective depth
// depends on prd_pkg
`default_nettype none

module prd_depth (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire prd_pkg::coef_t                    coef,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [prd_pkg::COORD_W-1:0] in_x,
    input  wire logic signed [prd_pkg::COORD_W-1:0] in_y,
    input  wire logic signed [prd_pkg::COORD_W-1:0] in_z,
    input  wire logic                              in_last,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output prd_pkg::depth_beat_t                   out_beat
);

    logic                                  v1_reg, v2_reg, v3_reg;
    logic                                  rdy1, rdy2, rdy3;
    logic signed [prd_pkg::COORD_W-1:0]    x1_reg, y1_reg, z1_reg;
    logic                                  last1_reg, last2_reg, last3_reg;
    logic signed [prd_pkg::PROD_W-1:0]     px_reg, py_reg, pz_reg;
    logic signed [prd_pkg::DEPTH_W-1:0]    depth3_reg;
    logic signed [prd_pkg::SUM_W-1:0]      sum;
    logic signed [prd_pkg::SUM_W-1:0]      sum_shr;
    logic signed [prd_pkg::SAT_W-1:0]      depth_wide;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // floor of the exact Q32.32 sum to Q16.16, then the offset
    always_comb begin
        sum = prd_pkg::SUM_W'(px_reg) + prd_pkg::SUM_W'(py_reg)
            + prd_pkg::SUM_W'(pz_reg);
        sum_shr = sum >>> prd_pkg::FRAC_W;
        depth_wide = prd_pkg::SAT_W'(sum_shr) + prd_pkg::SAT_W'($signed(coef.offset));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            x1_reg    <= in_x;
            y1_reg    <= in_y;
            z1_reg    <= in_z;
            last1_reg <= in_last;
        end
        if (rdy2 && v1_reg) begin
            px_reg    <= $signed(coef.x) * x1_reg;
            py_reg    <= $signed(coef.y) * y1_reg;
            pz_reg    <= $signed(coef.z) * z1_reg;
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg) begin
            depth3_reg <= prd_pkg::sat_depth(depth_wide);
            last3_reg  <= last2_reg;
        end
    end

    assign out_valid      = v3_reg;
    assign out_beat.depth = depth3_reg;
    assign out_beat.last  = last3_reg;

endmodule

`default_nettype wire

// File: sv/prd_widen.sv
// prd_widen: widens a finished depth range by the margin and holds the result
// in the output register; depends on prd_pkg
`default_nettype none

module prd_widen (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [prd_pkg::MARGIN_W-1:0]      margin_factor,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire prd_pkg::range_t                   in_range,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [prd_pkg::DEPTH_W-1:0]     out_min,
    output logic signed [prd_pkg::DEPTH_W-1:0]     out_max
);

    logic                                  v4_reg, v5_reg, vo_reg;
    logic                                  rdy4, rdy5, rdyo;
    logic signed [prd_pkg::DEPTH_W-1:0]    min4_reg, max4_reg, min5_reg, max5_reg;
    logic signed [prd_pkg::DEPTH_W-1:0]    min_o_reg, max_o_reg;
    logic signed [prd_pkg::MPROD_W-1:0]    mprod_reg;
    logic signed [prd_pkg::MPROD_W-1:0]    margin;
    logic signed [prd_pkg::SAT_W-1:0]      lo_wide, hi_wide;

    assign rdyo     = !vo_reg || out_ready;
    assign rdy5     = !v5_reg || rdyo;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    always_comb begin
        margin  = mprod_reg >>> prd_pkg::FRAC_W;
        lo_wide = prd_pkg::SAT_W'(min5_reg) - prd_pkg::SAT_W'(margin);
        hi_wide = prd_pkg::SAT_W'(max5_reg) + prd_pkg::SAT_W'(margin);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy4) begin
                v4_reg <= in_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdyo) begin
                vo_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && in_valid) begin
            min4_reg <= in_range.lo;
            max4_reg <= in_range.hi;
        end
        if (rdy5 && v4_reg) begin
            mprod_reg <= min4_reg * $signed({1'b0, margin_factor});
            min5_reg  <= min4_reg;
            max5_reg  <= max4_reg;
        end
        if (rdyo && v5_reg) begin
            min_o_reg <= prd_pkg::sat_depth(lo_wide);
            max_o_reg <= prd_pkg::sat_depth(hi_wide);
        end
    end

    assign out_valid = vo_reg;
    assign out_min   = min_o_reg;
    assign out_max   = max_o_reg;

endmodule

`default_nettype wire

// File: sv/projective_depth_range.sv
// projective_depth_range: top level with configuration registers and the
// per-feature min/max trackers; depends on prd_pkg, prd_depth, prd_widen
//
// usage
//  - s_ channel: one support point per transaction (x, y, z in Q16.16 and
//    is_last marking the final point of a feature)
//  - m_ channel: one transaction per feature, the widened depth range,
//    saturated to 48 bits
//  - cfg port: camera row coefficients, offset and margin factor, written
//    by index while the block is idle
// throughput: one point per cycle while s_ready is high; each point is registered,
//   multiplied, summed, then folded into the trackers in successive stages
// path: the range appears on m_valid once the last point of the feature
//   has passed the input, product, depth, range and margin product
//   registers, then the output register
// reset: configuration clears to zero, trackers start at 99999 and 0,
//   the pipeline empties
// stall: when m_ready is low the finished range waits in the output
//   register; points that are not the last of a feature keep flowing, and
//   s_ready drops only once the stages behind the output are full
`default_nettype none

module projective_depth_range (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [prd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [prd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [prd_pkg::COORD_W-1:0]    s_point_x,
    input  wire logic signed [prd_pkg::COORD_W-1:0]    s_point_y,
    input  wire logic signed [prd_pkg::COORD_W-1:0]    s_point_z,
    input  wire logic                                  s_is_last,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [prd_pkg::DEPTH_W-1:0]         m_range_min,
    output logic signed [prd_pkg::DEPTH_W-1:0]         m_range_max
);

    prd_pkg::coef_t                        coef_reg;
    logic [prd_pkg::MARGIN_W-1:0]          margin_reg;
    logic signed [prd_pkg::DEPTH_W-1:0]    run_min_reg, run_max_reg;
    logic signed [prd_pkg::DEPTH_W-1:0]    run_min_next, run_max_next;
    logic                                  d_valid, d_ready;
    prd_pkg::depth_beat_t                  d_beat;
    logic                                  w_ready;
    logic                                  d_take;
    prd_pkg::range_t                       fin_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg   <= '0;
            margin_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                prd_pkg::REG_ROW_X:      coef_reg.x      <= cfg_wdata;
                prd_pkg::REG_ROW_Y:      coef_reg.y      <= cfg_wdata;
                prd_pkg::REG_ROW_Z:      coef_reg.z      <= cfg_wdata;
                prd_pkg::REG_ROW_OFFSET: coef_reg.offset <= cfg_wdata;
                prd_pkg::REG_MARGIN:     margin_reg      <= cfg_wdata[prd_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    prd_depth u_depth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_x      (s_point_x),
        .in_y      (s_point_y),
        .in_z      (s_point_z),
        .in_last   (s_is_last),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_beat  (d_beat)
    );

    // a depth that ends a feature needs room in the widening stage
    assign d_ready = !d_beat.last || w_ready;
    assign d_take  = d_valid && d_ready;

    always_comb begin
        run_min_next = (d_beat.depth < run_min_reg) ? d_beat.depth : run_min_reg;
        run_max_next = (d_beat.depth > run_max_reg) ? d_beat.depth : run_max_reg;
        fin_range.lo = run_min_next;
        fin_range.hi = run_max_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_min_reg <= prd_pkg::MIN_START;
            run_max_reg <= '0;
        end else if (d_take) begin
            if (d_beat.last) begin
                run_min_reg <= prd_pkg::MIN_START;
                run_max_reg <= '0;
            end else begin
                run_min_reg <= run_min_next;
                run_max_reg <= run_max_next;
            end
        end
    end

    prd_widen u_widen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .margin_factor (margin_reg),
        .in_valid      (d_valid && d_beat.last),
        .in_ready      (w_ready),
        .in_range      (fin_range),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_min       (m_range_min),
        .out_max       (m_range_max)
    );

endmodule

`default_nettype wire
